FILE: rtl/core/tpep_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tpep_pkg;

    localparam int POOL_DEPTH = 16;
    localparam int IDX_W      = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int CNT_W      = $clog2(POOL_DEPTH + 1);
    localparam int KIND_COUNT = 5;
    localparam int TIER_COUNT = 3;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_QUERY  = 2'd2
    } t_op;

    localparam logic [2:0] ST_OBSERVED = 3'd0;
    localparam logic [2:0] ST_TESTING  = 3'd1;
    localparam logic [2:0] ST_PROMOTED = 3'd2;
    localparam logic [2:0] ST_DEMOTED  = 3'd3;

    localparam logic [1:0] TIER_PROMOTED = 2'd0;
    localparam logic [1:0] TIER_ACTIVE   = 2'd1;
    localparam logic [1:0] TIER_DEMOTED  = 2'd2;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    typedef struct packed {
        logic [63:0] site;
        logic [3:0]  width;
        logic [2:0]  kind;
        logic [2:0]  status;
    } t_entry;

    typedef struct packed {
        logic [63:0] site;
        logic [3:0]  width;
    } t_key;

    // First hit of one kind in one tier.
    typedef struct packed {
        logic             have;
        logic [IDX_W-1:0] idx;
        logic [1:0]       st;
    } t_tier;

    // Running scan result handed from cell to cell.
    typedef struct packed {
        t_tier [KIND_COUNT-1:0][TIER_COUNT-1:0] tiers;
        logic  [KIND_COUNT-1:0]                 presence;
    } t_acc;

endpackage

`default_nettype wire

FILE: rtl/core/tpep_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module tpep_cell
    import tpep_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [IDX_W-1:0] i_index,
    input  wire logic [CNT_W-1:0] i_fill,
    input  wire logic             i_wr_en,
    input  wire t_entry           i_wr,
    input  wire t_key             i_key,
    input  wire logic             i_tok,
    input  wire t_acc             i_acc,
    output logic                  o_tok,
    output t_acc                  o_acc
);

    t_entry r_entry;
    logic   r_tok;
    t_acc   r_acc;
    t_acc   n_acc;
    logic   w_live;
    logic   w_hit;
    logic [1:0] w_tier;

    // The entry register is written only when this cell is the next free slot.
    always_ff @(posedge i_clk) begin
        if (i_wr_en && (CNT_W'(i_index) == i_fill)) begin
            r_entry <= i_wr;
        end
    end

    assign w_live = (CNT_W'(i_index) < i_fill);

    always_comb begin
        w_tier = TIER_PROMOTED;
        w_hit  = w_live && (r_entry.site == i_key.site) && (r_entry.width == i_key.width)
                 && (r_entry.kind < 3'(KIND_COUNT));
        case (r_entry.status)
            ST_PROMOTED: w_tier = TIER_PROMOTED;
            ST_OBSERVED,
            ST_TESTING:  w_tier = TIER_ACTIVE;
            ST_DEMOTED:  w_tier = TIER_DEMOTED;
            default:     w_hit  = 1'b0;
        endcase
    end

    always_comb begin
        n_acc = i_acc;
        if (w_hit) begin
            n_acc.presence[r_entry.kind] = 1'b1;
            if (!i_acc.tiers[r_entry.kind][w_tier].have) begin
                n_acc.tiers[r_entry.kind][w_tier].have = 1'b1;
                n_acc.tiers[r_entry.kind][w_tier].idx  = i_index;
                n_acc.tiers[r_entry.kind][w_tier].st   = r_entry.status[1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= 1'b0;
        end else begin
            r_tok <= i_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tok) begin
            r_acc <= n_acc;
        end
    end

    assign o_tok = r_tok;
    assign o_acc = r_acc;

endmodule

`default_nettype wire

FILE: rtl/core/tiered_priority_entry_picker.sv
`timescale 1ns / 1ps
`default_nettype none

// Tiered priority entry picker. A transaction is taken when start is high and busy is low.
// Clear and append transactions finish in the cycle they are taken and give no result; busy
// stays low, so the next transaction may follow at once. A query transaction makes busy go
// high while a scan token walks the row of POOL_DEPTH storage cells, one cell per cycle. The
// token is launched from a register, passes through each cell in turn, and the pick is then
// resolved into the result registers. The result appears on the o_ ports for exactly one
// cycle, marked by o_valid. The receiver cannot stall it, so it must capture the result in
// that cycle. Appends to a full pool are dropped, and a clear only resets the fill count.

module tiered_priority_entry_picker
    import tpep_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_op,
    input  wire logic [63:0] i_site_address,
    input  wire logic [3:0]  i_operand_width,
    input  wire logic [2:0]  i_entry_kind,
    input  wire logic [2:0]  i_entry_status,
    input  wire logic [4:0]  i_reroll_grant,
    output logic             o_valid,
    output logic             o_found,
    output logic [3:0]       o_pick_index,
    output logic [2:0]       o_pick_kind,
    output logic [1:0]       o_pick_status,
    output logic [4:0]       o_presence_mask
);

    t_state r_state;
    t_state n_state;

    logic             r_launch;
    logic [CNT_W-1:0] r_fill;
    t_key             r_key;
    logic [4:0]       r_grant;

    logic             w_accept;
    logic             w_append;
    t_entry           w_wr;
    logic             w_tok [0:POOL_DEPTH];
    t_acc             w_acc [0:POOL_DEPTH];
    logic             w_last;

    logic             n_found;
    logic [3:0]       n_index;
    logic [2:0]       n_kind;
    logic [1:0]       n_status;

    assign w_accept = start && !busy;
    assign w_last   = w_tok[POOL_DEPTH];

    // Next-state logic: a query holds the block busy until the token leaves the last cell.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept && (t_op'(i_op) == OP_QUERY)) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Output logic of the state machine.
    always_comb begin
        case (r_state)
            S_IDLE:  busy = 1'b0;
            S_SCAN:  busy = 1'b1;
            default: busy = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_launch <= 1'b0;
            r_fill   <= '0;
        end else begin
            r_state  <= n_state;
            r_launch <= w_accept && (t_op'(i_op) == OP_QUERY);
            if (w_accept) begin
                case (t_op'(i_op))
                    OP_CLEAR:  r_fill <= '0;
                    OP_APPEND: begin
                        if (r_fill < CNT_W'(POOL_DEPTH)) begin
                            r_fill <= r_fill + CNT_W'(1);
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // The search key and grant bits are held for the whole scan.
    always_ff @(posedge i_clk) begin
        if (w_accept && (t_op'(i_op) == OP_QUERY)) begin
            r_key.site  <= i_site_address;
            r_key.width <= i_operand_width;
            r_grant     <= i_reroll_grant;
        end
    end

    // An append lands in the cell whose position equals the fill count. A full pool matches
    // no cell, so the entry is dropped.
    assign w_append  = w_accept && (t_op'(i_op) == OP_APPEND);
    assign w_wr.site   = i_site_address;
    assign w_wr.width  = i_operand_width;
    assign w_wr.kind   = i_entry_kind;
    assign w_wr.status = i_entry_status;

    assign w_tok[0] = r_launch;
    assign w_acc[0] = '0;

    // The row of storage cells. Each cell checks its own entry against the key and forwards
    // the running first-hit table to its neighbor.
    for (genvar g = 0; g < POOL_DEPTH; g++) begin : g_cell
        tpep_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_index (IDX_W'(g)),
            .i_fill  (r_fill),
            .i_wr_en (w_append),
            .i_wr    (w_wr),
            .i_key   (r_key),
            .i_tok   (w_tok[g]),
            .i_acc   (w_acc[g]),
            .o_tok   (w_tok[g+1]),
            .o_acc   (w_acc[g+1])
        );
    end

    // Tier resolution: kinds in order, and within a kind promoted, then observed or testing,
    // then demoted when that kind's grant bit is set. The first kind with a pick wins.
    always_comb begin
        n_found  = 1'b0;
        n_index  = '0;
        n_kind   = '0;
        n_status = '0;
        for (int k = 0; k < KIND_COUNT; k++) begin
            if (!n_found) begin
                if (w_acc[POOL_DEPTH].tiers[k][TIER_PROMOTED].have) begin
                    n_found  = 1'b1;
                    n_index  = 4'(w_acc[POOL_DEPTH].tiers[k][TIER_PROMOTED].idx);
                    n_kind   = 3'(k);
                    n_status = w_acc[POOL_DEPTH].tiers[k][TIER_PROMOTED].st;
                end else if (w_acc[POOL_DEPTH].tiers[k][TIER_ACTIVE].have) begin
                    n_found  = 1'b1;
                    n_index  = 4'(w_acc[POOL_DEPTH].tiers[k][TIER_ACTIVE].idx);
                    n_kind   = 3'(k);
                    n_status = w_acc[POOL_DEPTH].tiers[k][TIER_ACTIVE].st;
                end else if (w_acc[POOL_DEPTH].tiers[k][TIER_DEMOTED].have && r_grant[k]) begin
                    n_found  = 1'b1;
                    n_index  = 4'(w_acc[POOL_DEPTH].tiers[k][TIER_DEMOTED].idx);
                    n_kind   = 3'(k);
                    n_status = w_acc[POOL_DEPTH].tiers[k][TIER_DEMOTED].st;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= w_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_last) begin
            o_found         <= n_found;
            o_pick_index    <= n_index;
            o_pick_kind     <= n_kind;
            o_pick_status   <= n_status;
            o_presence_mask <= w_acc[POOL_DEPTH].presence;
        end
    end

endmodule

`default_nettype wire

FILE: tb/sv/tb_tiered_priority_entry_picker.sv
`timescale 1ns / 1ps

// Self-checking testbench for the tiered priority entry picker.
//
// The stimulus process drives one transaction at a time on the command port. A
// transaction is taken at a rising edge where start is high and busy is low. Clear and
// append transactions only change the pool. A query transaction yields exactly one
// result, which the block shows for a single cycle marked by o_valid. At the edge where
// a transaction is taken, the testbench updates its own copy of the pool. For a query it
// also pushes the expected result onto a FIFO. The monitor pops that FIFO on every
// o_valid strobe and compares the result field by field.

module tb_tiered_priority_entry_picker;
    import tpep_pkg::*;

    // Codes that the package does not name but the stimulus needs.
    localparam logic [1:0] OP_NONE    = 2'd3;    // undefined op, must be ignored
    localparam logic [2:0] ST_RETIRED = 3'd4;

    typedef enum logic [2:0] {
        KIND_EXACT    = 3'd0,
        KIND_ENUM     = 3'd1,
        KIND_BITMASK  = 3'd2,
        KIND_RANGE    = 3'd3,
        KIND_BOUNDARY = 3'd4
    } pick_kind_t;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 5;
    localparam int TARGET_ITEMS   = 600;
    // The slowest correct stretch with nothing taken is a long sender gap followed by one
    // full query scan, so this limit leaves a wide margin.
    localparam int QUIET_LIMIT    = 2000;
    localparam int TAIL_CYCLES    = POOL_DEPTH + 4;

    // One query result, laid out in the same order as the result ports.
    typedef struct packed {
        logic       found;
        logic [3:0] index;
        logic [2:0] kind;
        logic [1:0] status;
        logic [4:0] mask;
    } pick_result_t;

    // One row of stimulus. When spelled_out is set, the row carries its expected result
    // typed in by hand, and the predictor is not consulted for it.
    typedef struct {
        logic [1:0]   op;
        logic [63:0]  site;
        logic [3:0]   width;
        logic [2:0]   kind;
        logic [2:0]   status;
        logic [4:0]   grant;
        bit           spelled_out;
        pick_result_t want;
    } stim_row_t;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        start           = 1'b0;
    logic [1:0]  i_op            = OP_CLEAR;
    logic [63:0] i_site_address  = '0;
    logic [3:0]  i_operand_width = '0;
    logic [2:0]  i_entry_kind    = '0;
    logic [2:0]  i_entry_status  = '0;
    logic [4:0]  i_reroll_grant  = '0;
    logic        busy;
    logic        o_valid;
    logic        o_found;
    logic [3:0]  o_pick_index;
    logic [2:0]  o_pick_kind;
    logic [1:0]  o_pick_status;
    logic [4:0]  o_presence_mask;

    // The testbench's own image of the pool and the results still owed by the block.
    t_entry       pool_image [POOL_DEPTH];
    int           pool_fill = 0;
    pick_result_t owed_picks [$];

    int error_count  = 0;
    int items_taken  = 0;
    int quiet_cycles = 0;

    tiered_priority_entry_picker u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_op            (i_op),
        .i_site_address  (i_site_address),
        .i_operand_width (i_operand_width),
        .i_entry_kind    (i_entry_kind),
        .i_entry_status  (i_entry_status),
        .i_reroll_grant  (i_reroll_grant),
        .o_valid         (o_valid),
        .o_found         (o_found),
        .o_pick_index    (o_pick_index),
        .o_pick_kind     (o_pick_kind),
        .o_pick_status   (o_pick_status),
        .o_presence_mask (o_presence_mask)
    );

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Works out what a query returns against the current pool image.
    function automatic pick_result_t predict_pick(input logic [63:0] key_site,
                                                  input logic [3:0]  key_width,
                                                  input logic [4:0]  grant);
        pick_result_t r;
        bit           seen     [KIND_COUNT][TIER_COUNT];
        int           first_at [KIND_COUNT][TIER_COUNT];
        int           tier;
        int           sel;
        int           hit;
        r = '0;
        for (int k = 0; k < KIND_COUNT; k++) begin
            for (int t = 0; t < TIER_COUNT; t++) begin
                seen[k][t]     = 1'b0;
                first_at[k][t] = 0;
            end
        end
        // Record the first matching slot of each kind in each tier. Entries with an
        // unknown kind or status are skipped, and so are retired ones.
        for (int i = 0; i < pool_fill; i++) begin
            tier = -1;
            if (pool_image[i].site == key_site && pool_image[i].width == key_width &&
                pool_image[i].kind < KIND_COUNT) begin
                case (pool_image[i].status)
                    ST_PROMOTED:             tier = TIER_PROMOTED;
                    ST_OBSERVED, ST_TESTING: tier = TIER_ACTIVE;
                    ST_DEMOTED:              tier = TIER_DEMOTED;
                    default:                 tier = -1;
                endcase
            end
            if (tier >= 0) begin
                r.mask[pool_image[i].kind] = 1'b1;
                if (!seen[pool_image[i].kind][tier]) begin
                    seen[pool_image[i].kind][tier]     = 1'b1;
                    first_at[pool_image[i].kind][tier] = i;
                end
            end
        end
        // Walk the kinds from the lowest priority up, so that the last pick written is
        // the one from the highest-priority kind that has a pick at all.
        for (int k = KIND_COUNT - 1; k >= 0; k--) begin
            sel = -1;
            if (seen[k][TIER_PROMOTED])
                sel = TIER_PROMOTED;
            else if (seen[k][TIER_ACTIVE])
                sel = TIER_ACTIVE;
            else if (seen[k][TIER_DEMOTED] && grant[k])
                sel = TIER_DEMOTED;
            if (sel >= 0) begin
                hit      = first_at[k][sel];
                r.found  = 1'b1;
                r.index  = hit[3:0];
                r.kind   = pool_image[hit].kind;
                r.status = pool_image[hit].status[1:0];
            end
        end
        return r;
    endfunction

    function automatic stim_row_t mk_row(input logic [1:0] op, input logic [63:0] site,
                                         input logic [3:0] width, input logic [2:0] kind,
                                         input logic [2:0] status, input logic [4:0] grant,
                                         input bit spelled_out, input pick_result_t want);
        stim_row_t row;
        row.op          = op;
        row.site        = site;
        row.width       = width;
        row.kind        = kind;
        row.status      = status;
        row.grant       = grant;
        row.spelled_out = spelled_out;
        row.want        = want;
        return row;
    endfunction

    function automatic logic [63:0] rand_site();
        return {$urandom, $urandom};
    endfunction

    // Widths are mostly the legal operand sizes, but every 4-bit value turns up.
    function automatic logic [3:0] rand_width();
        if ($urandom_range(0, 4) != 0)
            return 4'd1 << $urandom_range(0, 3);
        return 4'($urandom_range(0, 15));
    endfunction

    function automatic void check_field(input string name, input logic [4:0] want,
                                        input logic [4:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            error_count++;
        end
    endfunction

    // Drives one transaction and holds it until the block takes it. The busy value read
    // right after the edge is the value that the edge itself sampled.
    task automatic issue(input stim_row_t row);
        start           <= 1'b1;
        i_op            <= row.op;
        i_site_address  <= row.site;
        i_operand_width <= row.width;
        i_entry_kind    <= row.kind;
        i_entry_status  <= row.status;
        i_reroll_grant  <= row.grant;
        @(posedge i_clk);
        while (busy !== 1'b0)
            @(posedge i_clk);
        // Taken at this edge: bring the pool image up to date.
        case (row.op)
            OP_CLEAR: begin
                pool_fill = 0;
                items_taken++;
            end
            OP_APPEND: begin
                // An append to a full pool is dropped without a trace.
                if (pool_fill < POOL_DEPTH) begin
                    pool_image[pool_fill] = '{row.site, row.width, row.kind, row.status};
                    pool_fill++;
                end
                items_taken++;
            end
            OP_QUERY: begin
                if (row.spelled_out)
                    owed_picks.push_back(row.want);
                else
                    owed_picks.push_back(predict_pick(row.site, row.width, row.grant));
                items_taken++;
            end
            default: ;
        endcase
    endtask

    // Random sender gap: mostly none or short, now and then long. A burst has no gaps.
    task automatic idle_after(input bit burst);
        int n;
        n = 0;
        if (!burst) begin
            case ($urandom_range(0, 9))
                0:          n = $urandom_range(10, 40);
                1, 2, 3:    n = $urandom_range(1, 3);
                default:    n = 0;
            endcase
        end
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Holds the sender off until every owed result has come back.
    task automatic drain_results();
        if (owed_picks.size() != 0) begin
            start <= 1'b0;
            while (owed_picks.size() != 0)
                @(posedge i_clk);
        end
    endtask

    // Result monitor and watchdog. The values read here are the ones the edge sampled.
    always @(posedge i_clk) begin
        pick_result_t got;
        pick_result_t want;
        if (i_rst_n) begin
            if ($isunknown(o_valid)) begin
                $display("%0t ns: o_valid is unknown, expected 0 or 1", $time);
                error_count++;
            end else if (o_valid) begin
                got = {o_found, o_pick_index, o_pick_kind, o_pick_status, o_presence_mask};
                if (owed_picks.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none, got %h", $time, got);
                    error_count++;
                end else begin
                    want = owed_picks.pop_front();
                    check_field("found", 5'(want.found), 5'(got.found));
                    check_field("pick_index", 5'(want.index), 5'(got.index));
                    check_field("pick_kind", 5'(want.kind), 5'(got.kind));
                    check_field("pick_status", 5'(want.status), 5'(got.status));
                    check_field("presence_mask", want.mask, got.mask);
                end
            end
        end
        if (o_valid === 1'b1 || (start && busy === 1'b0))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t ns: watchdog expired, %0d results still owed", $time,
                     owed_picks.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // Stimulus: a directed table first, then random fill-and-query sequences.
    initial begin
        stim_row_t   directed_rows [25];
        stim_row_t   row;
        logic [63:0] key_site  [3];
        logic [3:0]  key_width [3];
        logic [63:0] hi_site;
        logic [63:0] mid_site;
        int          n_app;
        int          n_query;
        int          pick;
        int          seq_count;
        bit          burst;

        hi_site  = 64'h8000_0000_0000_0000;
        mid_site = 64'h5555_5555_5555_5555;

        // Query on the empty pool right after reset: nothing present, nothing picked.
        directed_rows[0]  = mk_row(OP_QUERY, '0, 4'd1, '0, '0, 5'h1f, 1, '0);
        directed_rows[1]  = mk_row(OP_CLEAR, '1, '1, '1, '1, '1, 0, '0);
        // Extreme sites and widths: all zeros, and all ones with width 15.
        directed_rows[2]  = mk_row(OP_APPEND, '0, 4'd1, KIND_EXACT, ST_PROMOTED, '0, 0, '0);
        directed_rows[3]  = mk_row(OP_APPEND, '1, 4'd15, KIND_BOUNDARY, ST_DEMOTED, '0, 0, '0);
        // A demoted entry is present but only picked once its kind's grant bit is set.
        directed_rows[4]  = mk_row(OP_QUERY, '1, 4'd15, '0, '0, 5'b00000, 1,
                                   '{1'b0, 4'd0, 3'd0, 2'd0, 5'b10000});
        directed_rows[5]  = mk_row(OP_QUERY, '1, 4'd15, '0, '0, 5'b10000, 1,
                                   '{1'b1, 4'd1, KIND_BOUNDARY, ST_DEMOTED[1:0], 5'b10000});
        directed_rows[6]  = mk_row(OP_QUERY, '0, 4'd1, '0, '0, 5'b00000, 1,
                                   '{1'b1, 4'd0, KIND_EXACT, ST_PROMOTED[1:0], 5'b00001});
        // An entry with an out-of-range kind, one with an out-of-range status and a
        // retired one are all stored but must never show up in a query.
        directed_rows[7]  = mk_row(OP_APPEND, '0, 4'd1, 3'd7, ST_OBSERVED, '0, 0, '0);
        directed_rows[8]  = mk_row(OP_APPEND, '0, 4'd1, KIND_ENUM, 3'd7, '0, 0, '0);
        directed_rows[9]  = mk_row(OP_APPEND, '0, 4'd1, KIND_ENUM, ST_RETIRED, '0, 0, '0);
        directed_rows[10] = mk_row(OP_APPEND, '0, 4'd1, KIND_ENUM, ST_TESTING, '0, 0, '0);
        directed_rows[11] = mk_row(OP_QUERY, '0, 4'd1, '0, '0, 5'b00000, 1,
                                   '{1'b1, 4'd0, KIND_EXACT, ST_PROMOTED[1:0], 5'b00011});
        // The undefined op must leave the pool alone and give no result.
        directed_rows[12] = mk_row(OP_NONE, '1, '1, '1, '1, '1, 0, '0);
        // The width is part of the key: same site, other width, no match.
        directed_rows[13] = mk_row(OP_QUERY, '0, 4'd2, '0, '0, 5'h1f, 1, '0);
        directed_rows[14] = mk_row(OP_CLEAR, '0, '0, '0, '0, '0, 0, '0);
        directed_rows[15] = mk_row(OP_QUERY, '0, 4'd1, '0, '0, 5'h1f, 1, '0);
        // Kind order: enum outranks bitmask, but only when its demoted entry is granted.
        directed_rows[16] = mk_row(OP_APPEND, hi_site, 4'd8, KIND_BITMASK, ST_OBSERVED,
                                   '0, 0, '0);
        directed_rows[17] = mk_row(OP_APPEND, hi_site, 4'd8, KIND_RANGE, ST_TESTING,
                                   '0, 0, '0);
        directed_rows[18] = mk_row(OP_APPEND, hi_site, 4'd8, KIND_ENUM, ST_DEMOTED,
                                   '0, 0, '0);
        directed_rows[19] = mk_row(OP_QUERY, hi_site, 4'd8, '0, '0, 5'b00000, 1,
                                   '{1'b1, 4'd0, KIND_BITMASK, ST_OBSERVED[1:0], 5'b01110});
        directed_rows[20] = mk_row(OP_QUERY, hi_site, 4'd8, '0, '0, 5'b00010, 1,
                                   '{1'b1, 4'd2, KIND_ENUM, ST_DEMOTED[1:0], 5'b01110});
        // Tier order inside one kind is left to the predictor.
        directed_rows[21] = mk_row(OP_APPEND, mid_site, 4'd4, KIND_EXACT, ST_DEMOTED,
                                   '0, 0, '0);
        directed_rows[22] = mk_row(OP_APPEND, mid_site, 4'd4, KIND_EXACT, ST_OBSERVED,
                                   '0, 0, '0);
        directed_rows[23] = mk_row(OP_APPEND, mid_site, 4'd4, KIND_EXACT, ST_PROMOTED,
                                   '0, 0, '0);
        directed_rows[24] = mk_row(OP_QUERY, mid_site, 4'd4, '0, '0, 5'h1f, 0, '0);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            issue(directed_rows[i]);
            idle_after(1'b0);
        end

        // Random part. Each sequence usually empties the pool, fills it with entries
        // drawn mostly from a few shared keys, and then queries those keys, so that the
        // queries hit several kinds and tiers at once. Some sequences skip the clear,
        // and some append more than the pool holds, so the full-pool drop gets exercised.
        seq_count = 0;
        while (items_taken < TARGET_ITEMS) begin
            burst = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < 3; k++) begin
                case ($urandom_range(0, 9))
                    0:       key_site[k] = '0;
                    1:       key_site[k] = '1;
                    default: key_site[k] = rand_site();
                endcase
                key_width[k] = rand_width();
            end

            if ($urandom_range(0, 9) != 0) begin
                issue(mk_row(OP_CLEAR, rand_site(), 4'($urandom), 3'($urandom),
                             3'($urandom), 5'($urandom), 0, '0));
                idle_after(burst);
            end

            n_app = $urandom_range(1, 20);
            for (int a = 0; a < n_app; a++) begin
                pick = $urandom_range(0, 2);
                row  = mk_row(OP_APPEND, key_site[pick], key_width[pick],
                              ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                                          : 3'($urandom_range(0, 4)),
                              ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                                          : 3'($urandom_range(0, 4)),
                              5'($urandom), 0, '0);
                if ($urandom_range(0, 6) == 0) begin
                    row.site  = rand_site();
                    row.width = rand_width();
                end
                issue(row);
                idle_after(burst);
            end

            n_query = $urandom_range(1, 6);
            for (int q = 0; q < n_query; q++) begin
                pick = $urandom_range(0, 2);
                row  = mk_row(OP_QUERY, key_site[pick], key_width[pick], 3'($urandom),
                              3'($urandom), 5'($urandom), 0, '0);
                case ($urandom_range(0, 9))
                    0:       row.site = rand_site();
                    1:       row.width = 4'($urandom);
                    default: ;
                endcase
                issue(row);
                idle_after(burst);
            end

            // Occasional noise: a transaction with the undefined op and random fields.
            if ($urandom_range(0, 4) == 0) begin
                issue(mk_row(OP_NONE, rand_site(), 4'($urandom), 3'($urandom),
                             3'($urandom), 5'($urandom), 0, '0));
                idle_after(burst);
            end

            // The first sequence, and some later ones, wait for every result to return.
            if (seq_count == 0 || $urandom_range(0, 7) == 0)
                drain_results();
            seq_count++;
        end

        // Let the last results come back, then wait out the tail so the block can show any
        // stray strobe before the verdict.
        drain_results();
        start <= 1'b0;
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (owed_picks.size() != 0) begin
            $display("%0t ns: %0d results never arrived, expected 0 owed", $time,
                     owed_picks.size());
            error_count++;
        end
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
